// ===== sv/mrir_pkg.sv =====
`default_nettype none
package mrir_pkg;

    localparam logic [1:0] K_TX     = 2'd0;
    localparam logic [1:0] K_VALUE  = 2'd1;
    localparam logic [1:0] K_STATUS = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CRC      = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_FIRST_REGISTER = 2'd1;
    localparam logic [1:0] CFG_REGISTER_COUNT = 2'd2;

    localparam logic [7:0]  FUNC_READ_INPUT = 8'd4;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    typedef enum logic [1:0] {
        J_SEND = 2'd0,
        J_STAT = 2'd1,
        J_READ = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [1:0]  status;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [6:0]  cnt;
    } t_job;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== sv/mrir_ram.sv =====
`default_nettype none
module mrir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/mrir_queue.sv =====
`default_nettype none
module mrir_queue
    import mrir_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty
);
    t_job       r_ent [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_ent[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_job;
        end
    end
endmodule
`default_nettype wire

// ===== sv/mrir_front.sv =====
`default_nettype none
module mrir_front
    import mrir_pkg::*;
#(
    parameter int MAX_REGS = 32,
    parameter int AW       = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic          i_command,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_frame_start,
    input  wire logic [7:0]    i_slave_address,
    input  wire logic [5:0]    i_register_count,
    input  wire logic          i_unlock,
    output logic               o_q_push,
    output t_job               o_q_job,
    input  wire logic          i_q_full,
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [15:0]        o_ram_wdata
);
    typedef enum logic [6:0] {
        P_ADDR  = 7'b0000001,
        P_FUNC  = 7'b0000010,
        P_COUNT = 7'b0000100,
        P_DATA  = 7'b0001000,
        P_CRCLO = 7'b0010000,
        P_CRCHI = 7'b0100000,
        P_DONE  = 7'b1000000
    } t_phase;

    t_phase      r_phase, n_phase, ph;
    logic [15:0] r_crc, n_crc, crc_cur, crc_byte;
    logic [7:0]  r_pos, n_pos, pos_cur, pos_inc;
    logic [7:0]  r_total, n_total;
    logic [7:0]  r_addr, n_addr, r_func, n_func;
    logic [7:0]  r_high, n_high, r_crclo, n_crclo;
    logic        r_lock, n_lock;
    logic        accept, rx;
    logic [6:0]  idx;
    logic [15:0] got;
    logic        ok;

    assign o_full  = i_q_full || r_lock;
    assign accept  = i_push && !o_full;
    assign rx      = accept && i_command;

    assign ph       = i_frame_start ? P_ADDR : r_phase;
    assign crc_cur  = i_frame_start ? CRC_INIT : r_crc;
    assign pos_cur  = i_frame_start ? 8'd0 : r_pos;
    assign crc_byte = crc_update(crc_cur, i_rx_byte);
    assign pos_inc  = pos_cur + 8'd1;
    assign idx      = pos_cur[7:1];
    assign got      = {i_rx_byte, r_crclo};
    assign ok = (r_addr == i_slave_address) && (r_func == FUNC_READ_INPUT) &&
                ({1'b0, r_total} == {2'b0, i_register_count, 1'b0}) &&
                ({1'b0, r_total} <= 9'(2 * MAX_REGS));

    assign o_ram_waddr = idx[AW-1:0];
    assign o_ram_wdata = {r_high, i_rx_byte};

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_pos    = r_pos;
        n_total  = r_total;
        n_addr   = r_addr;
        n_func   = r_func;
        n_high   = r_high;
        n_crclo  = r_crclo;
        n_lock   = r_lock && !i_unlock;
        o_q_push = 1'b0;
        o_ram_we = 1'b0;
        o_q_job  = '{kind: J_SEND, status: ST_OK, addr: r_addr, func: r_func,
                     cnt: r_total[7:1]};
        if (accept && !i_command) begin
            o_q_push = 1'b1;
        end else if (rx) begin
            n_phase = ph;
            n_crc   = crc_cur;
            n_pos   = pos_cur;
            case (ph)
                P_ADDR: begin
                    n_addr  = i_rx_byte;
                    n_crc   = crc_byte;
                    n_phase = P_FUNC;
                end
                P_FUNC: begin
                    n_func  = i_rx_byte;
                    n_crc   = crc_byte;
                    n_phase = P_COUNT;
                end
                P_COUNT: begin
                    n_total = i_rx_byte;
                    n_pos   = 8'd0;
                    n_crc   = crc_byte;
                    n_phase = (i_rx_byte == 8'd0) ? P_CRCLO : P_DATA;
                end
                P_DATA: begin
                    n_crc = crc_byte;
                    if (!pos_cur[0]) begin
                        n_high = i_rx_byte;
                    end else if (idx < 7'(MAX_REGS)) begin
                        o_ram_we = 1'b1;
                    end
                    n_pos = pos_inc;
                    if (pos_inc == r_total) n_phase = P_CRCLO;
                end
                P_CRCLO: begin
                    n_crclo = i_rx_byte;
                    n_phase = P_CRCHI;
                end
                P_CRCHI: begin
                    n_phase  = P_DONE;
                    o_q_push = 1'b1;
                    if (got != r_crc) begin
                        o_q_job.kind   = J_STAT;
                        o_q_job.status = ST_CRC;
                    end else if (!ok) begin
                        o_q_job.kind   = J_STAT;
                        o_q_job.status = ST_MISMATCH;
                    end else begin
                        o_q_job.kind = J_READ;
                        n_lock       = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_ADDR;
            r_crc   <= CRC_INIT;
            r_pos   <= 8'd0;
            r_total <= 8'd0;
            r_addr  <= 8'd0;
            r_func  <= 8'd0;
            r_high  <= 8'd0;
            r_crclo <= 8'd0;
            r_lock  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
            r_pos   <= n_pos;
            r_total <= n_total;
            r_addr  <= n_addr;
            r_func  <= n_func;
            r_high  <= n_high;
            r_crclo <= n_crclo;
            r_lock  <= n_lock;
        end
    end
endmodule
`default_nettype wire

// ===== sv/mrir_back.sv =====
`default_nettype none
module mrir_back
    import mrir_pkg::*;
#(
    parameter int MAX_REGS = 32,
    parameter int AW       = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_slave_address,
    input  wire logic [15:0]   i_first_register,
    input  wire logic [5:0]    i_register_count,
    input  t_job               i_q_job,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    output logic               o_unlock,
    output logic [AW-1:0]      o_ram_raddr,
    input  wire logic [15:0]   i_ram_rdata,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_tx_byte,
    output logic [7:0]         o_resp_address,
    output logic [15:0]        o_register_number,
    output logic [15:0]        o_register_value,
    output logic [1:0]         o_status,
    output logic [7:0]         o_resp_function,
    output logic               o_last
);
    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_SEND  = 5'b00010,
        B_RWAIT = 5'b00100,
        B_ROUT  = 5'b01000,
        B_STAT  = 5'b10000
    } t_bstate;

    t_bstate     r_state;
    t_job        r_job;
    logic [6:0]  r_idx;
    logic [15:0] r_crc;
    logic        r_valid;
    logic        out_free;
    logic        out_load;
    logic [7:0]  tx;

    assign o_empty     = !r_valid;
    assign out_free    = !r_valid || i_pop;
    assign out_load    = out_free &&
                         (r_state == B_SEND || r_state == B_ROUT || r_state == B_STAT);
    assign o_q_pop     = (r_state == B_IDLE) && !i_q_empty;
    assign o_ram_raddr = r_idx[AW-1:0];
    assign o_unlock    = (r_state == B_STAT) && out_free && (r_job.kind == J_READ);

    always_comb begin
        case (r_idx[2:0])
            3'd0:    tx = i_slave_address;
            3'd1:    tx = FUNC_READ_INPUT;
            3'd2:    tx = i_first_register[15:8];
            3'd3:    tx = i_first_register[7:0];
            3'd4:    tx = 8'd0;
            3'd5:    tx = {2'b0, i_register_count};
            3'd6:    tx = r_crc[7:0];
            default: tx = r_crc[15:8];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= out_load || (r_valid && !i_pop);
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        case (i_q_job.kind)
                            J_SEND:  r_state <= B_SEND;
                            J_READ:  r_state <= (i_q_job.cnt == 7'd0) ? B_STAT : B_RWAIT;
                            default: r_state <= B_STAT;
                        endcase
                    end
                end
                B_SEND: begin
                    if (out_free) begin
                        if (r_idx[2:0] == 3'd7) r_state <= B_IDLE;
                    end
                end
                B_RWAIT: r_state <= B_ROUT;
                B_ROUT: begin
                    if (out_free) begin
                        r_state <= (r_idx + 7'd1 == r_job.cnt) ? B_STAT : B_RWAIT;
                    end
                end
                B_STAT: begin
                    if (out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // payload and job registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_q_job;
                r_idx <= 7'd0;
                r_crc <= CRC_INIT;
            end
            B_SEND: begin
                if (out_free) begin
                    o_kind            <= K_TX;
                    o_tx_byte         <= tx;
                    o_resp_address    <= 8'd0;
                    o_register_number <= 16'd0;
                    o_register_value  <= 16'd0;
                    o_status          <= ST_OK;
                    o_resp_function   <= 8'd0;
                    o_last            <= (r_idx[2:0] == 3'd7);
                    r_idx             <= r_idx + 7'd1;
                    if (r_idx[2:0] < 3'd6) r_crc <= crc_update(r_crc, tx);
                end
            end
            B_ROUT: begin
                if (out_free) begin
                    o_kind            <= K_VALUE;
                    o_tx_byte         <= 8'd0;
                    o_resp_address    <= r_job.addr;
                    o_register_number <= i_first_register + {9'd0, r_idx};
                    o_register_value  <= i_ram_rdata;
                    o_status          <= ST_OK;
                    o_resp_function   <= r_job.func;
                    o_last            <= 1'b0;
                    r_idx             <= r_idx + 7'd1;
                end
            end
            B_STAT: begin
                if (out_free) begin
                    o_kind            <= K_STATUS;
                    o_tx_byte         <= 8'd0;
                    o_resp_address    <= r_job.addr;
                    o_register_number <= 16'd0;
                    o_register_value  <= 16'd0;
                    o_status          <= r_job.status;
                    o_resp_function   <= r_job.func;
                    o_last            <= 1'b1;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/modbus_read_input_regs_master.sv =====
// channel   direction  handshake        payload
// input     in         i_push / o_full  i_command, i_rx_byte, i_frame_start
// result    out        o_empty / i_pop  o_kind .. o_last (one register stage)
// config    in         i_cfg_wr_en      i_cfg_index, i_cfg_data
//
// Response bytes are taken one per cycle while input does not stall; each byte's CRC update is done as it is taken.
// A request yields 8 transmit results, one per cycle from the back end's sequencer while the output is not stalled.
// A good response is read out of the value buffer value by value (states B_RWAIT, B_ROUT), plus status.
// Input stalls while the job queue is full or a buffer readout is still pending.
// Reset (synchronous, active low) clears control state; the buffer is not cleared.
`default_nettype none
module modbus_read_input_regs_master
    import mrir_pkg::*;
#(
    parameter int MAX_REGS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_frame_start,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_tx_byte,
    output logic [7:0]       o_resp_address,
    output logic [15:0]      o_register_number,
    output logic [15:0]      o_register_value,
    output logic [1:0]       o_status,
    output logic [7:0]       o_resp_function,
    output logic             o_last,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

    logic [7:0]  r_slave_address;
    logic [15:0] r_first_register;
    logic [5:0]  r_register_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address  <= 8'd1;
            r_first_register <= 16'd0;
            r_register_count <= 6'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SLAVE_ADDRESS:  r_slave_address  <= i_cfg_data[7:0];
                CFG_FIRST_REGISTER: r_first_register <= i_cfg_data;
                CFG_REGISTER_COUNT: r_register_count <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic          q_push, q_full, q_pop, q_empty, unlock;
    t_job          q_in, q_out;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    mrir_front #(.MAX_REGS(MAX_REGS)) u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_command, .i_rx_byte, .i_frame_start,
        .i_slave_address (r_slave_address),
        .i_register_count(r_register_count),
        .i_unlock        (unlock),
        .o_q_push        (q_push),
        .o_q_job         (q_in),
        .i_q_full        (q_full),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata)
    );

    mrir_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push (q_push),
        .i_job  (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_job  (q_out),
        .o_empty(q_empty)
    );

    mrir_ram #(.WIDTH(16), .DEPTH(MAX_REGS), .AW(AW)) u_buf (
        .i_clk,
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    mrir_back #(.MAX_REGS(MAX_REGS)) u_back (
        .i_clk, .i_rst_n,
        .i_slave_address (r_slave_address),
        .i_first_register(r_first_register),
        .i_register_count(r_register_count),
        .i_q_job         (q_out),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .o_unlock        (unlock),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata),
        .o_empty, .i_pop, .o_kind, .o_tx_byte, .o_resp_address, .o_register_number,
        .o_register_value, .o_status, .o_resp_function, .o_last
    );
endmodule
`default_nettype wire

// ===== sv/mrir_checker.sv =====
`default_nettype none
module mrir_checker
    import mrir_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_empty,
    input wire logic        i_pop,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_tx_byte,
    input wire logic [7:0]  o_resp_address,
    input wire logic [1:0]  o_status,
    input wire logic        o_last
);
    a_value_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind == K_VALUE) |-> !o_last)
        else $error("register value marked last");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_kind == K_TX || o_kind == K_VALUE || o_kind == K_STATUS))
        else $error("illegal result kind");

    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind == K_TX) |-> (o_status == ST_OK && o_resp_address == 8'd0))
        else $error("transmit result carries response fields");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_kind) && $stable(o_tx_byte)))
        else $error("stalled result changed");
endmodule

bind modbus_read_input_regs_master mrir_checker u_checker (
    .i_clk, .i_rst_n, .o_empty, .i_pop, .o_kind, .o_tx_byte, .o_resp_address,
    .o_status, .o_last
);
`default_nettype wire
